@@ rtl/upd_pkg.sv @@
`timescale 1ns / 1ps

package upd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    // Width of the signed escape index arithmetic; covers -3024..1304.
    localparam int IDX_W = 13;

    localparam logic signed [IDX_W-1:0] CH_TWO        = 13'sd50;
    localparam logic signed [IDX_W-1:0] CH_ZERO       = 13'sd48;
    localparam logic signed [IDX_W-1:0] CH_NINE       = 13'sd57;
    localparam logic signed [IDX_W-1:0] LETTER_OFFSET = 13'sd55;
    localparam logic signed [IDX_W-1:0] NEWLINE_INDEX = -13'sd22;
    localparam logic signed [IDX_W-1:0] PRINTABLE_COUNT = 13'sd95;

    // One beat of encoded text.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } in_beat_t;

    // One beat of decoded text.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } out_beat_t;

    // Outcome of decoding a held escape.
    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_result_t;

endpackage

@@ rtl/upd_escape_decode.sv @@
`timescale 1ns / 1ps

module upd_escape_decode
    import upd_pkg::*;
(
    input  logic [7:0]  first_digit,
    input  logic [7:0]  second_digit,
    output esc_result_t result
);

    logic signed [IDX_W-1:0] first_ext;
    logic signed [IDX_W-1:0] second_ext;
    logic signed [IDX_W-1:0] hi;
    logic signed [IDX_W-1:0] lo;
    logic signed [IDX_W-1:0] index;

    // Both digits are taken as signed bytes.
    assign first_ext  = $signed({{(IDX_W-8){first_digit[7]}}, first_digit});
    assign second_ext = $signed({{(IDX_W-8){second_digit[7]}}, second_digit});

    // High term, low term and the combined index (high term times sixteen).
    assign hi    = first_ext - CH_TWO;
    assign lo    = (second_ext <= CH_NINE) ? (second_ext - CH_ZERO)
                                           : (second_ext - LETTER_OFFSET);
    assign index = $signed({hi[IDX_W-5:0], 4'b0000}) + lo;

    // A newline index wins; otherwise only printable indexes map to a byte.
    always_comb
    begin
        result.hit   = 1'b0;
        result.value = 8'h00;
        if (index == NEWLINE_INDEX)
        begin
            result.hit   = 1'b1;
            result.value = CH_NEWLINE;
        end
        else if (!hi[IDX_W-1] && !index[IDX_W-1] && (index < PRINTABLE_COUNT))
        begin
            result.hit   = 1'b1;
            result.value = CH_SPACE + index[7:0];
        end
    end

endmodule

@@ rtl/url_percent_decoder.sv @@
// A beat is accepted into the input register and moves on to the result register, from
// which its result is offered, whenever that register is free.
// Throughput: one beat per cycle while results are taken; with the result port stalled,
// one more beat waits in the input register before the input stalls.
// Beats that decode to nothing, and are not the last of a text, give no result.
// Reset (rst_n low, asynchronous) empties both stages and returns the escape state to idle.
`timescale 1ns / 1ps

module url_percent_decoder
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enc_valid,
    output logic      enc_ready,
    input  in_beat_t  enc_beat,
    output logic      dec_valid,
    input  logic      dec_ready,
    output out_beat_t dec_beat
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_FIRST   = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  first_digit_reg, first_digit_next;
    logic        s1_valid_reg, s1_valid_next;
    in_beat_t    s1_beat_reg, s1_beat_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_beat_reg, out_beat_next;

    logic        s1_fire;
    logic        emit;
    logic        hit;
    logic [7:0]  value;
    esc_result_t esc;

    // Escape decoding of the held first digit with the current byte.
    upd_escape_decode u_escape_decode (
        .first_digit  (first_digit_reg),
        .second_digit (s1_beat_reg.in_byte),
        .result       (esc)
    );

    // Stage advance: the input stage moves on whenever the result register is free.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || dec_ready);
    assign enc_ready = !s1_valid_reg || s1_fire;
    assign dec_valid = out_valid_reg;
    assign dec_beat  = out_beat_reg;

    // Escape state machine and per-byte decode.
    always_comb
    begin
        phase_next       = phase_reg;
        first_digit_next = first_digit_reg;
        hit              = 1'b0;
        value            = 8'h00;
        unique case (phase_reg)
            PH_PERCENT:
            begin
                first_digit_next = s1_beat_reg.in_byte;
                phase_next       = PH_FIRST;
            end
            PH_FIRST:
            begin
                hit        = esc.hit;
                value      = esc.value;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (s1_beat_reg.in_byte == CH_PERCENT)
                begin
                    phase_next = PH_PERCENT;
                end
                else if (s1_beat_reg.in_byte == CH_PLUS)
                begin
                    hit   = 1'b1;
                    value = CH_SPACE;
                end
                else
                begin
                    hit   = 1'b1;
                    value = s1_beat_reg.in_byte;
                end
            end
        endcase
        if (s1_beat_reg.last_in)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign emit = hit || s1_beat_reg.last_in;

    // Next values of the pipeline registers.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_beat_next  = s1_beat_reg;
        if (enc_valid && enc_ready)
        begin
            s1_valid_next = 1'b1;
            s1_beat_next  = enc_beat;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (s1_fire && emit)
        begin
            out_valid_next            = 1'b1;
            out_beat_next.out_byte    = hit ? value : 8'h00;
            out_beat_next.byte_valid  = hit;
            out_beat_next.end_of_text = s1_beat_reg.last_in;
        end
        else if (dec_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            first_digit_reg <= 8'h00;
            s1_valid_reg    <= 1'b0;
            s1_beat_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_beat_reg    <= '0;
        end
        else
        begin
            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                first_digit_reg <= first_digit_next;
            end
            s1_valid_reg  <= s1_valid_next;
            s1_beat_reg   <= s1_beat_next;
            out_valid_reg <= out_valid_next;
            out_beat_reg  <= out_beat_next;
        end
    end

    // A result without a decoded byte exists only to mark the end of a text.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_beat.byte_valid) |-> dec_beat.end_of_text)
        else $error("empty result without end of text");

    // An empty result carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_beat.byte_valid) |-> (dec_beat.out_byte == 8'h00))
        else $error("empty result carries nonzero byte");

    // The last byte of a text always leaves the escape state idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_beat_reg.last_in) |=> (phase_reg == PH_IDLE))
        else $error("escape state not cleared at end of text");

    // A decoded byte always reaches the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> dec_valid)
        else $error("result lost between stages");

endmodule

@@ tb/url_decode_checker.sv @@
`timescale 1ns / 1ps

module url_decode_checker
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enc_valid,
    input  logic      enc_ready,
    input  in_beat_t  enc_beat,
    input  logic      dec_valid,
    input  logic      dec_ready,
    input  out_beat_t dec_beat,
    output int        fail_count,
    output int        pending_count
);

    // Where the decoder stands inside a percent escape.
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PERCENT,
        ESC_FIRST,
        ESC_UNUSED
    } esc_phase_t;

    // Offsets of the escape index arithmetic, on signed bytes.
    localparam int HI_BASE        = 'h32;
    localparam int DIGIT_BASE     = 'h30;
    localparam int LAST_DIGIT     = 'h39;
    localparam int LETTER_BASE    = 'h41 - 10;
    localparam int DIGIT_WEIGHT   = 16;
    localparam int NEWLINE_IDX    = -22;
    localparam int PRINTABLE_SPAN = 95;

    esc_phase_t esc_phase;
    logic [7:0] held_first;
    out_beat_t  decoded_q[$];

    // Turns the two held escape bytes into a character, if they mean one.
    function automatic bit decode_escape_pair(input logic [7:0] first,
                                              input logic [7:0] second,
                                              output logic [7:0] ch);
        int f;
        int s;
        int hi;
        int lo;
        int idx;
        f  = $signed(first);
        s  = $signed(second);
        hi = f - HI_BASE;
        lo = (s <= LAST_DIGIT) ? s - DIGIT_BASE : s - LETTER_BASE;
        idx = hi * DIGIT_WEIGHT + lo;
        ch = 8'h00;
        if (idx == NEWLINE_IDX)
        begin
            ch = CH_NEWLINE;
            return 1'b1;
        end
        if (hi >= 0 && idx >= 0 && idx < PRINTABLE_SPAN)
        begin
            ch = CH_SPACE + idx[7:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the escape state by one encoded beat and queues the decoded beat it yields.
    function automatic void decode_text_beat(input in_beat_t beat);
        logic [7:0] ch;
        bit         emit;
        out_beat_t  res;
        ch   = 8'h00;
        emit = 1'b0;
        case (esc_phase)
            ESC_PERCENT:
            begin
                held_first = beat.in_byte;
                esc_phase  = ESC_FIRST;
            end
            ESC_FIRST:
            begin
                emit      = decode_escape_pair(held_first, beat.in_byte, ch);
                esc_phase = ESC_IDLE;
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                if (beat.in_byte == CH_PERCENT)
                begin
                    esc_phase = ESC_PERCENT;
                end
                else if (beat.in_byte == CH_PLUS)
                begin
                    ch   = CH_SPACE;
                    emit = 1'b1;
                end
                else
                begin
                    ch   = beat.in_byte;
                    emit = 1'b1;
                end
            end
        endcase
        if (beat.last_in)
            esc_phase = ESC_IDLE;
        if (emit || beat.last_in)
        begin
            res.out_byte    = emit ? ch : 8'h00;
            res.byte_valid  = emit;
            res.end_of_text = beat.last_in;
            decoded_q.push_back(res);
        end
    endfunction

    // Counts a failure; only the first few are described.
    function automatic void note_failure(input string what);
        if (fail_count < 10)
            $display("[%0t] decode mismatch: %s", $realtime, what);
        fail_count = fail_count + 1;
    endfunction

    // Watch both channels at the rising edge; encoded beats first, then decoded ones.
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t want;
        if (!rst_n)
        begin
            esc_phase  = ESC_IDLE;
            held_first = 8'h00;
            fail_count = 0;
            decoded_q.delete();
        end
        else
        begin
            if (enc_valid && enc_ready)
                decode_text_beat(enc_beat);
            if (dec_valid && dec_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected beat byte=%h valid=%b end=%b",
                                           dec_beat.out_byte, dec_beat.byte_valid,
                                           dec_beat.end_of_text));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (dec_beat.out_byte !== want.out_byte
                        || dec_beat.byte_valid !== want.byte_valid
                        || dec_beat.end_of_text !== want.end_of_text)
                    begin
                        note_failure($sformatf(
                            "expected byte=%h valid=%b end=%b, got byte=%h valid=%b end=%b",
                            want.out_byte, want.byte_valid, want.end_of_text,
                            dec_beat.out_byte, dec_beat.byte_valid, dec_beat.end_of_text));
                    end
                end
            end
        end
        pending_count = decoded_q.size();
    end

endmodule

@@ tb/tb_url_percent_decoder.sv @@
`timescale 1ns / 1ps

module tb_url_percent_decoder
    import upd_pkg::*;
();

    localparam int LONG_HOLD_CYCLES = 80;
    localparam int ITEMS_PER_PHASE  = 300;
    localparam int PHASE_COUNT      = 5;
    localparam int PRESSURE_PHASE   = 4;

    logic      clk;
    logic      rst_n;
    logic      enc_valid;
    logic      enc_ready;
    in_beat_t  enc_beat;
    logic      dec_valid;
    logic      dec_ready;
    out_beat_t dec_beat;

    int fail_count;
    int pending_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int long_hold_tag;
    int sent_in_phase;

    url_percent_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_beat  (enc_beat),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_beat  (dec_beat)
    );

    url_decode_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .enc_valid     (enc_valid),
        .enc_ready     (enc_ready),
        .enc_beat      (enc_beat),
        .dec_valid     (dec_valid),
        .dec_ready     (dec_ready),
        .dec_beat      (dec_beat),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running 2 ns clock.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off each time the tag moves.
    initial
    begin : receiver
        int hold_left;
        int seen_tag;
        hold_left = 0;
        seen_tag  = 0;
        dec_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_tag != seen_tag)
            begin
                seen_tag  = long_hold_tag;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                dec_ready <= 1'b0;
            end
            else
            begin
                dec_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Offers one encoded beat, starting and ending at a falling edge.
    task automatic send_text_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            enc_valid <= 1'b0;
            @(negedge clk);
        end
        enc_valid         <= 1'b1;
        enc_beat.in_byte  <= b;
        enc_beat.last_in  <= last;
        do
            @(posedge clk);
        while (!enc_ready);
        sent_in_phase = sent_in_phase + 1;
        @(negedge clk);
    endtask

    // Stops offering beats until every expected decoded beat has come out.
    task automatic drain_decoder();
        enc_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic pick_last();
        return ($urandom_range(24) == 0);
    endfunction

    // First escape byte: mostly near the printable range, sometimes anything.
    function automatic logic [7:0] pick_first_digit();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range('h37, 'h30));
        if (r < 80)
            return 8'($urandom_range('h3F, 'h28));
        return 8'($urandom_range(255));
    endfunction

    // Second escape byte: decimal digits, hex letters, other ASCII or any byte.
    function automatic logic [7:0] pick_second_digit();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'($urandom_range('h39, 'h30));
        if (r < 65)
            return 8'($urandom_range('h46, 'h41));
        if (r < 75)
            return 8'($urandom_range('h7F, 'h3A));
        return 8'($urandom_range(255));
    endfunction

    // One random piece of text: an escape, a plus, or a raw byte.
    task automatic send_random_chunk();
        int kind;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            send_text_byte(CH_PERCENT, pick_last());
            send_text_byte(pick_first_digit(), pick_last());
            send_text_byte(pick_second_digit(), pick_last());
        end
        else if (kind < 50)
        begin
            send_text_byte(CH_PLUS, pick_last());
        end
        else
        begin
            send_text_byte(8'($urandom_range(255)), pick_last());
        end
    endtask

    // Stimulus: directed text, then random phases with different idling.
    initial
    begin
        enc_valid          = 1'b0;
        enc_beat           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_hold_tag      = 0;
        sent_in_phase      = 0;
        @(posedge rst_n);
        @(negedge clk);

        // Raw byte extremes, the final byte of a text passing through, and a plus.
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(CH_PLUS, 1'b0);
        // Letter, newline by index, and the top of the printable range.
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("4", 1'b0);
        send_text_byte("1", 1'b0);
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("0", 1'b0);
        send_text_byte("A", 1'b0);
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("7", 1'b0);
        send_text_byte("E", 1'b1);
        // Just past the printable range, ending the text with nothing decoded.
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("7", 1'b0);
        send_text_byte("F", 1'b1);
        // A negative second byte cancels a large first term into a space.
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte(8'h3D, 1'b0);
        send_text_byte(8'h80, 1'b0);
        // A negative first term reaching the newline index.
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("1", 1'b0);
        send_text_byte("*", 1'b0);
        // Escapes cut short by the end of the text.
        send_text_byte(CH_PERCENT, 1'b1);
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte("4", 1'b1);
        // Escape with no meaning, followed by a plain final byte.
        send_text_byte(CH_PERCENT, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte("0", 1'b0);
        send_text_byte("z", 1'b1);
        drain_decoder();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:       begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                3:       begin sender_idle_pct = 30; receiver_stall_pct = 30; end
                default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            endcase
            // Long receiver hold while beats keep coming, so the input backs up.
            if (phase == PRESSURE_PHASE)
                long_hold_tag = long_hold_tag + 1;
            sent_in_phase = 0;
            while (sent_in_phase < ITEMS_PER_PHASE)
                send_random_chunk();
            drain_decoder();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
